// ----- rtl/gn3_pkg.sv -----
// Shared types and constants for the 3D gradient noise block.
// No dependencies; imported by gn3_perm_bank, gradient_noise_3d and the testbench.

package gn3_pkg;

  // Permutation table geometry.
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = 8;
  localparam int BYTE_W        = 8;

  // Result format: signed Q2.16.
  localparam int OUT_W    = 18;
  localparam int OUT_FRAC = 16;
  localparam int OUT_MAX  = 131071;
  localparam int OUT_MIN  = -131072;

  // Hash codes in the upper half that take x as the second gradient term.
  localparam logic [3:0] GRAD_X_LO = 4'd12;
  localparam logic [3:0] GRAD_X_HI = 4'd14;

  // Item kinds.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  // Write port of one copy of the permutation table.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } perm_wr_t;

endpackage

// ----- rtl/gn3_perm_bank.sv -----
// One copy of the permutation table: one write port, two registered read ports.
// Depends on gn3_pkg. Unwritten entries read as their own index.

module gn3_perm_bank import gn3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  perm_wr_t          wr_i,
  input  logic [IDX_W-1:0]  raddr_a_i,
  input  logic [IDX_W-1:0]  raddr_b_i,
  output logic [BYTE_W-1:0] rdata_a_o,
  output logic [BYTE_W-1:0] rdata_b_o
);

  logic [BYTE_W-1:0]        mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] written_q;
  logic [BYTE_W-1:0]        rd_a_q, rd_b_q;
  logic [IDX_W-1:0]         addr_a_q, addr_b_q;
  logic                     hit_a_q, hit_b_q;

  // Storage and registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (en_i) begin
      rd_a_q   <= mem_q[raddr_a_i];
      rd_b_q   <= mem_q[raddr_b_i];
      addr_a_q <= raddr_a_i;
      addr_b_q <= raddr_b_i;
    end
  end

  // Written flags; a clear flag makes the entry read as the identity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      hit_a_q   <= 1'b0;
      hit_b_q   <= 1'b0;
    end else begin
      if (wr_i.we) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (en_i) begin
        hit_a_q <= written_q[raddr_a_i];
        hit_b_q <= written_q[raddr_b_i];
      end
    end
  end

  assign rdata_a_o = hit_a_q ? rd_a_q : addr_a_q;
  assign rdata_b_o = hit_b_q ? rd_b_q : addr_b_q;

endmodule

// ----- rtl/gradient_noise_3d.sv -----
// Top level of the 3D improved gradient noise pipeline.
// Depends on gn3_pkg and gn3_perm_bank.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | valid_i / stall_o  | opcode_i, coord_x/y/z_i, entry_index_i, entry_value_i
//  out     | valid_o / stall_i  | noise_value_o
//
// One item enters per cycle unless the pipeline is stalled; an evaluate item's result
// passes through nine register stages including the output register.
// The depth is set by the three dependent table lookups and the four fade multiplies.
// Each lookup stage holds its own table copies; a load writes them as it passes, so items
// stay in order. Load items give no result.
// A held result freezes the whole pipeline; reset restores the identity table at once.

module gradient_noise_3d import gn3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic              opcode_i,
  input  logic [23:0]       coord_x_i,
  input  logic [23:0]       coord_y_i,
  input  logic [23:0]       coord_z_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        entry_value_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic signed [OUT_W-1:0] noise_value_o
);

  localparam int F  = FRAC_BITS;
  localparam int FW = F + 5;   // fade intermediates
  localparam int GW = F + 2;   // relative coordinates and fade results
  localparam int LW = F + 6;   // gradients and blends
  localparam int D  = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int U  = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int RW = (F >= OUT_FRAC) ? LW : LW + U;

  localparam logic signed [FW-1:0] C15   = FW'(15 * (1 << F));
  localparam logic signed [FW-1:0] C10   = FW'(10 * (1 << F));
  localparam logic signed [GW-1:0] ONE_G = GW'(1 << F);
  localparam int                   HALF  = 1 << (F - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

  // Rounded fixed-point product of a fraction and a fade intermediate.
  function automatic logic signed [FW-1:0] fstep(input logic [F-1:0] t,
                                                 input logic signed [FW-1:0] a);
    logic signed [F+FW:0] p;
    p = $signed({1'b0, t}) * a;
    p = p + (F+FW+1)'(HALF);
    return FW'(p >>> F);
  endfunction

  // a + round(t * (b - a)).
  function automatic logic signed [LW-1:0] lerp_f(input logic signed [GW-1:0] t,
                                                  input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
    logic signed [LW:0]      d;
    logic signed [LW+GW:0]   p;
    d = (LW+1)'(b) - (LW+1)'(a);
    p = t * d;
    p = p + (LW+GW+1)'(HALF);
    return a + LW'(p >>> F);
  endfunction

  // Gradient dot product selected by the low four hash bits.
  function automatic logic signed [LW-1:0] grad_f(input logic [3:0] h,
                                                  input logic signed [GW-1:0] x,
                                                  input logic signed [GW-1:0] y,
                                                  input logic signed [GW-1:0] z);
    logic signed [GW-1:0] gu, gv;
    logic signed [LW-1:0] su, sv;
    gu = (h[3] == 1'b0) ? x : y;
    if (h[3:2] == 2'b00) begin
      gv = y;
    end else if (h == GRAD_X_LO || h == GRAD_X_HI) begin
      gv = x;
    end else begin
      gv = z;
    end
    su = h[0] ? -LW'(gu) : LW'(gu);
    sv = h[1] ? -LW'(gv) : LW'(gv);
    return su + sv;
  endfunction

  // Global advance: the pipeline moves unless a held result is stalled.
  logic       en;
  logic       out_vld_q;
  logic [8:1] vld_q;
  logic [8:1] op_q;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;
  assign valid_o = out_vld_q;

  // Stage registers.
  logic [7:0]   int_q1 [3];
  logic [F-1:0] fr_q1 [3], fr_q2 [3], fr_q3 [3], fr_q4 [3];
  logic [7:0]   y_q2, z_q2, z_q3;
  logic [7:0]   wi_q1, wv_q1, wi_q2, wv_q2, wi_q3, wv_q3;
  logic signed [FW-1:0] m_q2 [3], m_q3 [3], m_q4 [3];
  logic signed [GW-1:0] fd_q5 [3];
  logic signed [GW-1:0] v_q6, w_q6, w_q7;
  logic signed [LW-1:0] g_q5 [8];
  logic signed [LW-1:0] l_q6 [4];
  logic signed [LW-1:0] l_q7 [2];
  logic signed [LW-1:0] r_q8;
  logic signed [OUT_W-1:0] out_q;

  // Output scaling results.
  logic signed [RW-1:0]    conv;
  logic signed [OUT_W-1:0] sat_out;

  // Table lookup data, registered inside the banks.
  logic [7:0] d1 [2];
  logic [7:0] d2 [4];
  logic [7:0] h4 [8];

  logic [31:0] coord_ext [3];
  assign coord_ext[0] = 32'(coord_x_i);
  assign coord_ext[1] = 32'(coord_y_i);
  assign coord_ext[2] = 32'(coord_z_i);

  // Control: valid and opcode per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      op_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[7:1], valid_i};
      op_q      <= {op_q[7:1], opcode_i};
      out_vld_q <= vld_q[8] && (op_q[8] == OP_EVAL);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        int_q1[a] <= coord_ext[a][F+7:F];
        fr_q1[a]  <= coord_ext[a][F-1:0];
        fr_q2[a]  <= fr_q1[a];
        fr_q3[a]  <= fr_q2[a];
        fr_q4[a]  <= fr_q3[a];
        // Fade, one rounded multiply per stage.
        m_q2[a]   <= fstep(fr_q1[a], FW'({fr_q1[a], 2'b00}) + FW'({fr_q1[a], 1'b0}) - C15)
                     + C10;
        m_q3[a]   <= fstep(fr_q2[a], m_q2[a]);
        m_q4[a]   <= fstep(fr_q3[a], m_q3[a]);
        fd_q5[a]  <= GW'(fstep(fr_q4[a], m_q4[a]));
      end
      wi_q1 <= entry_index_i;
      wv_q1 <= entry_value_i;
      wi_q2 <= wi_q1;
      wv_q2 <= wv_q1;
      wi_q3 <= wi_q2;
      wv_q3 <= wv_q2;
      y_q2  <= int_q1[1];
      z_q2  <= int_q1[2];
      z_q3  <= z_q2;
      // Gradients at the eight corners; bit 0 of the corner is x, bit 1 y, bit 2 z.
      for (int c = 0; c < 8; c++) begin
        g_q5[c] <= grad_f(h4[c][3:0],
                          c[0] ? $signed({2'b00, fr_q4[0]}) - ONE_G
                               : $signed({2'b00, fr_q4[0]}),
                          c[1] ? $signed({2'b00, fr_q4[1]}) - ONE_G
                               : $signed({2'b00, fr_q4[1]}),
                          c[2] ? $signed({2'b00, fr_q4[2]}) - ONE_G
                               : $signed({2'b00, fr_q4[2]}));
      end
      // Trilinear blend along x, then y, then z.
      for (int m = 0; m < 4; m++) begin
        l_q6[m] <= lerp_f(fd_q5[0], g_q5[2*m], g_q5[2*m+1]);
      end
      v_q6 <= fd_q5[1];
      w_q6 <= fd_q5[2];
      for (int n = 0; n < 2; n++) begin
        l_q7[n] <= lerp_f(v_q6, l_q6[2*n], l_q6[2*n+1]);
      end
      w_q7 <= w_q6;
      r_q8 <= lerp_f(w_q7, l_q7[0], l_q7[1]);
      out_q <= sat_out;
    end
  end

  // Output scaling to 16 fraction bits and saturation.
  if (F > OUT_FRAC) begin : g_down
    assign conv = RW'((r_q8 + LW'(1 << (D - 1))) >>> D);
  end else if (F == OUT_FRAC) begin : g_same
    assign conv = r_q8;
  end else begin : g_up
    assign conv = RW'(r_q8) <<< U;
  end

  always_comb begin
    if (conv > SAT_HI) begin
      sat_out = OUT_W'(SAT_HI);
    end else if (conv < SAT_LO) begin
      sat_out = OUT_W'(SAT_LO);
    end else begin
      sat_out = OUT_W'(conv);
    end
  end

  assign noise_value_o = out_q;

  // Table copies, written by a load as it passes each lookup stage.
  perm_wr_t wr1, wr2, wr3;
  assign wr1 = '{we: en && vld_q[1] && (op_q[1] == OP_LOAD), addr: wi_q1, data: wv_q1};
  assign wr2 = '{we: en && vld_q[2] && (op_q[2] == OP_LOAD), addr: wi_q2, data: wv_q2};
  assign wr3 = '{we: en && vld_q[3] && (op_q[3] == OP_LOAD), addr: wi_q3, data: wv_q3};

  // First lookup: p[X] and p[X+1].
  gn3_perm_bank u_bank1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .wr_i      (wr1),
    .raddr_a_i (int_q1[0]),
    .raddr_b_i (int_q1[0] + 8'd1),
    .rdata_a_o (d1[0]),
    .rdata_b_o (d1[1])
  );

  // Second lookup: p[A], p[A+1] and p[B], p[B+1].
  for (genvar i = 0; i < 2; i++) begin : g_lvl2
    gn3_perm_bank u_bank2 (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .wr_i      (wr2),
      .raddr_a_i (d1[i] + y_q2),
      .raddr_b_i (d1[i] + y_q2 + 8'd1),
      .rdata_a_o (d2[i]),
      .rdata_b_o (d2[i+2])
    );
  end

  // Third lookup: the eight corner hashes.
  for (genvar k = 0; k < 4; k++) begin : g_lvl3
    gn3_perm_bank u_bank3 (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .wr_i      (wr3),
      .raddr_a_i (d2[k] + z_q3),
      .raddr_b_i (d2[k] + z_q3 + 8'd1),
      .rdata_a_o (h4[k]),
      .rdata_b_o (h4[k+4])
    );
  end

  // A stall is only raised while a result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stall_o |-> out_vld_q)
    else $error("stall raised with no held result");

  // A result appears exactly when an evaluate item leaves the last stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   en |=> out_vld_q == ($past(vld_q[8]) && $past(op_q[8]) == OP_EVAL))
    else $error("result valid does not match last stage");

  // An accepted item occupies the first stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_i && !stall_o) |=> vld_q[1])
    else $error("accepted item lost at stage one");

  // A frozen pipeline keeps its stage valid bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !en |=> $stable(vld_q))
    else $error("stage valids moved during a stall");

endmodule

// ----- test/gradient_noise_3d_tb.sv -----
// Self-checking testbench for the 3D gradient noise block.
// Depends on gn3_pkg and gradient_noise_3d; drives table loads and evaluates,
// predicts every noise result in the testbench and compares it at the output.

module gradient_noise_3d_tb;
  import gn3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    opcode_e     op;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] cz;
    logic [7:0]  idx;
    logic [7:0]  val;
  } noise_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic opcode_i = 1'b0;
  logic [23:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [7:0] entry_index_i = '0, entry_value_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [OUT_W-1:0] noise_value_o;

  gradient_noise_3d dut (.*);

  always #5 clk_i = ~clk_i;

  noise_item_t pending_items[$];
  logic signed [OUT_W-1:0] expected_noise[$];
  logic [7:0] perm_model[TABLE_ENTRIES];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit in_taken = 1'b0;

  // Rounded fixed-point product, half up, floor shift.
  function automatic longint round_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint fade_curve(longint t);
    longint r;
    r = 6 * t - 15 * ONE;
    r = round_mul(t, r) + 10 * ONE;
    r = round_mul(t, r);
    r = round_mul(t, r);
    return round_mul(t, r);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + round_mul(t, b - a);
  endfunction

  function automatic longint corner_grad(logic [7:0] hash, longint x, longint y,
                                         longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == GRAD_X_LO || h == GRAD_X_HI) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] lookup(logic [7:0] i);
    return perm_model[i];
  endfunction

  // Full noise evaluation against the testbench copy of the table.
  function automatic logic signed [OUT_W-1:0] noise_at(logic [23:0] cx, logic [23:0] cy,
                                                      logic [23:0] cz);
    logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
    longint x, y, z, u, v, w, l1, l2, l3, l4, r;
    xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
    x = longint'(cx[15:0]); y = longint'(cy[15:0]); z = longint'(cz[15:0]);
    u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
    a = lookup(xi) + yi;
    aa = lookup(a) + zi;
    ab = lookup(a + 8'd1) + zi;
    b = lookup(xi + 8'd1) + yi;
    ba = lookup(b) + zi;
    bb = lookup(b + 8'd1) + zi;
    l1 = blend(u, corner_grad(lookup(aa), x, y, z),
               corner_grad(lookup(ba), x - ONE, y, z));
    l2 = blend(u, corner_grad(lookup(ab), x, y - ONE, z),
               corner_grad(lookup(bb), x - ONE, y - ONE, z));
    l3 = blend(u, corner_grad(lookup(aa + 8'd1), x, y, z - ONE),
               corner_grad(lookup(ba + 8'd1), x - ONE, y, z - ONE));
    l4 = blend(u, corner_grad(lookup(ab + 8'd1), x, y - ONE, z - ONE),
               corner_grad(lookup(bb + 8'd1), x - ONE, y - ONE, z - ONE));
    r = blend(w, blend(v, l1, l2), blend(v, l3, l4));
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  function automatic noise_item_t make_eval(logic [23:0] cx, logic [23:0] cy,
                                            logic [23:0] cz);
    noise_item_t it;
    it.op = OP_EVAL; it.cx = cx; it.cy = cy; it.cz = cz;
    it.idx = 8'($urandom); it.val = 8'($urandom);
    return it;
  endfunction

  function automatic noise_item_t make_load(logic [7:0] idx, logic [7:0] val);
    noise_item_t it;
    it.op = OP_LOAD; it.idx = idx; it.val = val;
    it.cx = 24'($urandom); it.cy = 24'($urandom); it.cz = 24'($urandom);
    return it;
  endfunction

  // Random coordinate, sometimes on a lattice point, at the top of the fraction or at its midpoint.
  function automatic logic [23:0] rand_coord();
    logic [23:0] c;
    c = 24'($urandom);
    case ($urandom_range(0, 7))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[15:0] = 16'h8000;
      default: ;
    endcase
    return c;
  endfunction

  // Driver: presents queued items, changes inputs at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        void'(pending_items.pop_front());
      end
      if (!(valid_i && !in_taken)) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          valid_i       <= 1'b1;
          opcode_i      <= pending_items[0].op;
          coord_x_i     <= pending_items[0].cx;
          coord_y_i     <= pending_items[0].cy;
          coord_z_i     <= pending_items[0].cz;
          entry_index_i <= pending_items[0].idx;
          entry_value_i <= pending_items[0].val;
        end else begin
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on accepted inputs and checks accepted results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    // Input acceptance as seen at this edge, for the driver.
    in_taken <= valid_i && !stall_o;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        if (opcode_i == OP_LOAD) begin
          perm_model[entry_index_i] = entry_value_i;
        end else begin
          expected_noise.push_back(noise_at(coord_x_i, coord_y_i, coord_z_i));
        end
      end
      if (valid_o && !stall_i) begin
        if (expected_noise.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value_o);
          error_count++;
        end else begin
          if (noise_value_o !== expected_noise[0]) begin
            $error("noise_value: expected %0d, actual %0d", expected_noise[0],
                   noise_value_o);
            error_count++;
          end
          void'(expected_noise.pop_front());
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Queues a phase of random items: mostly evaluates, some table loads.
  task automatic queue_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 20) begin
        pending_items.push_back(make_load(8'($urandom), 8'($urandom)));
      end else begin
        pending_items.push_back(make_eval(rand_coord(), rand_coord(), rand_coord()));
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || valid_i) @(posedge clk_i);
    while (expected_noise.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) perm_model[i] = 8'(i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity table corners and extremes, then loads and reuse.
    pending_items.push_back(make_eval(24'h000000, 24'h000000, 24'h000000));
    pending_items.push_back(make_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    pending_items.push_back(make_eval(24'h008000, 24'h008000, 24'h008000));
    pending_items.push_back(make_eval(24'hFF0000, 24'h00FFFF, 24'h7F8000));
    pending_items.push_back(make_eval(24'h00FFFF, 24'hFF0001, 24'h000001));
    pending_items.push_back(make_eval(24'hAAAAAA, 24'h555555, 24'hFFFF00));
    pending_items.push_back(make_load(8'd0, 8'd255));
    pending_items.push_back(make_load(8'd255, 8'd0));
    pending_items.push_back(make_load(8'd1, 8'hAA));
    pending_items.push_back(make_eval(24'h000000, 24'h000000, 24'h000000));
    pending_items.push_back(make_eval(24'hFF4000, 24'hFFC000, 24'h00FFFF));
    // Hash values 12 and 14 pick x as the second term; make them reachable.
    pending_items.push_back(make_load(8'd2, 8'd12));
    pending_items.push_back(make_load(8'd3, 8'd14));
    pending_items.push_back(make_load(8'd4, 8'd15));
    pending_items.push_back(make_eval(24'h01C000, 24'h004000, 24'h02A000));
    pending_items.push_back(make_eval(24'h02FFFF, 24'h01FFFF, 24'h00FFFF));
    for (int i = 0; i < 6; i++)
      pending_items.push_back(make_eval(24'($urandom), 24'($urandom), 24'($urandom)));
    drain();

    // Random phases with different idle and stall mixes.
    send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(420); drain();
    send_idle_pct = 61; recv_stall_pct = 0;  queue_random(420); drain();
    send_idle_pct = 0;  recv_stall_pct = 61; queue_random(420); drain();
    send_idle_pct = 30; recv_stall_pct = 30; queue_random(420); drain();

    repeat (30) @(posedge clk_i);
    if (error_count == 0 && expected_noise.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- gradient_noise_3d.f -----
rtl/gn3_pkg.sv
rtl/gn3_perm_bank.sv
rtl/gradient_noise_3d.sv
test/gradient_noise_3d_tb.sv
